[rtl/socd_key_pair_resolver_core_assert.svh]
// Assertion macros for the SOCD key pair resolver.
// Used by rtl/socd_key_pair_resolver_core.sv; depends on nothing else.
`ifndef SOCD_KEY_PAIR_RESOLVER_CORE_ASSERT_SVH
`define SOCD_KEY_PAIR_RESOLVER_CORE_ASSERT_SVH

// Same-cycle implication, checked on every rising clock edge outside reset.
`define SKPR_ASSERT_IMP(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, checked on every rising clock edge outside reset.
`define SKPR_ASSERT_NXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

[rtl/skpr_pkg.sv]
// Shared types and constants for the SOCD key pair resolver.
// Used by rtl/socd_key_pair_resolver_core.sv and tb/sv/tb_top.sv; depends on nothing else.
package skpr_pkg;

   // Key map and storage geometry.
   localparam int KEYS      = 128;
   localparam int PAIRS     = 6;
   localparam int LANES     = 8;
   localparam int ROWS      = KEYS / LANES;
   localparam int KEY_W     = 7;
   localparam int LANE_W    = $clog2(LANES);
   localparam int ROW_W     = $clog2(ROWS);
   localparam int PIDX_W    = $clog2(PAIRS + 1);
   localparam int TIME_W    = 32;
   localparam int COUNT_W   = 8;
   localparam int HALF_W    = 64;
   localparam int PAIR_W    = 17;

   // Configuration port.
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 17;
   localparam logic [CSR_IDX_W-1:0] CSR_ENABLE    = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_PAIR_BASE = 3'd1;

   // Reset contents of the pair registers.
   localparam logic [PAIR_W-1:0] PAIR0_RESET = 17'd69662;
   localparam logic [PAIR_W-1:0] PAIR1_RESET = 17'd69520;

   // Resolution modes.
   typedef enum logic [1:0] {
      MODE_NEWER = 2'd0,
      MODE_BOTH  = 2'd1,
      MODE_OLDER = 2'd2,
      MODE_NONE  = 2'd3
   } skpr_mode_type;

   // One opposing-pair register.
   typedef struct packed {
      logic                valid;
      skpr_mode_type       mode;
      logic [KEY_W-1:0]    key2;
      logic [KEY_W-1:0]    key1;
   } skpr_pair_type;

   // Sequencer states.
   typedef enum logic [1:0] {
      ST_IDLE  = 2'd0,
      ST_SWEEP = 2'd1,
      ST_PAIR  = 2'd2,
      ST_DONE  = 2'd3
   } skpr_state_type;

endpackage

[rtl/socd_key_pair_resolver_core.sv]
// SOCD key pair resolver top level; uses skpr_pkg and socd_key_pair_resolver_core_assert.svh.
// With enable set, an accepted transaction first sweeps the press-time memory one row of 8 keys
// at a time, then feeds the six pairs through the shared time comparator before rsp_valid rises.
// With enable clear, rsp_valid rises in the cycle after the transaction is accepted.
// A new transaction is accepted only once the previous result has been taken and the block is idle.
// Reset (synchronous, active high) releases all tracked keys and restores the registers.
module socd_key_pair_resolver_core (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_stall,
   input  logic [skpr_pkg::HALF_W-1:0]        req_keys_low,
   input  logic [skpr_pkg::HALF_W-1:0]        req_keys_high,
   input  logic [skpr_pkg::COUNT_W-1:0]       req_key_count,
   input  logic [skpr_pkg::TIME_W-1:0]        req_time_ms,
   output logic                               rsp_valid,
   input  logic                               rsp_stall,
   output logic [skpr_pkg::HALF_W-1:0]        rsp_resolved_low,
   output logic [skpr_pkg::HALF_W-1:0]        rsp_resolved_high,
   input  logic                               csr_we,
   input  logic [skpr_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [skpr_pkg::CSR_DATA_W-1:0]    csr_wdata
);

`include "socd_key_pair_resolver_core_assert.svh"

   typedef logic [skpr_pkg::LANES-1:0][skpr_pkg::TIME_W-1:0] row_type;

   skpr_pkg::skpr_state_type state_ff, state_in;
   logic                              enable_ff;
   skpr_pkg::skpr_pair_type           pair_cfg_ff [skpr_pkg::PAIRS];
   logic [skpr_pkg::KEYS-1:0]         raw_ff, raw_in;
   logic [skpr_pkg::KEYS-1:0]         bm_ff, bm_in;
   logic [skpr_pkg::COUNT_W-1:0]      count_ff, count_in;
   logic [skpr_pkg::TIME_W-1:0]       time_ff;
   logic [skpr_pkg::ROW_W-1:0]        row_ff, row_in;
   logic [skpr_pkg::PIDX_W-1:0]       rp_ff, rp_in;
   skpr_pkg::skpr_pair_type           cur_ff, fetch_cfg;
   row_type                           time_mem [skpr_pkg::ROWS];
   row_type                           rd1_ff, rd2_ff;

   logic                              req_accept;
   logic [skpr_pkg::KEY_W-1:0]        row_base;
   logic [skpr_pkg::LANES-1:0]        row_pressed, row_raw, row_raw_new, wmask;
   logic                              pair_eval, pair_ok, clr1, clr2, t_ge, t_le;
   logic [skpr_pkg::TIME_W-1:0]       t1, t2;
   logic [skpr_pkg::KEYS-1:0]         clear_mask;

   assign req_accept = req_valid && !req_stall;

   // Handshake outputs follow the sequencer state.
   always_comb begin
      req_stall         = (state_ff != skpr_pkg::ST_IDLE);
      rsp_valid         = (state_ff == skpr_pkg::ST_DONE);
      rsp_resolved_low  = bm_ff[skpr_pkg::HALF_W-1:0];
      rsp_resolved_high = bm_ff[skpr_pkg::KEYS-1:skpr_pkg::HALF_W];
   end

   // Next state of the sequencer.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         skpr_pkg::ST_IDLE: begin
            if (req_valid) begin
               state_in = enable_ff ? skpr_pkg::ST_SWEEP : skpr_pkg::ST_DONE;
            end
         end
         skpr_pkg::ST_SWEEP: begin
            if (row_ff == skpr_pkg::ROW_W'(skpr_pkg::ROWS - 1)) begin
               state_in = skpr_pkg::ST_PAIR;
            end
         end
         skpr_pkg::ST_PAIR: begin
            if (rp_ff == skpr_pkg::PIDX_W'(skpr_pkg::PAIRS)) begin
               state_in = skpr_pkg::ST_DONE;
            end
         end
         skpr_pkg::ST_DONE: begin
            if (!rsp_stall) begin
               state_in = skpr_pkg::ST_IDLE;
            end
         end
         default: state_in = skpr_pkg::ST_IDLE;
      endcase
   end

   // Sweep of one row of keys: detect fresh presses and update tracking bits.
   always_comb begin
      row_base    = {row_ff, {skpr_pkg::LANE_W{1'b0}}};
      row_pressed = bm_ff[row_base +: skpr_pkg::LANES];
      row_raw     = raw_ff[row_base +: skpr_pkg::LANES];
      for (int l = 0; l < skpr_pkg::LANES; l++) begin
         logic in_range;
         in_range = {1'b0, row_ff, skpr_pkg::LANE_W'(l)} < count_ff;
         wmask[l] = (state_ff == skpr_pkg::ST_SWEEP) && in_range
                    && row_pressed[l] && !row_raw[l];
         row_raw_new[l] = in_range ? row_pressed[l] : row_raw[l];
      end
      raw_in = raw_ff;
      if (state_ff == skpr_pkg::ST_SWEEP) begin
         raw_in[row_base +: skpr_pkg::LANES] = row_raw_new;
      end
   end

   // Pair fetch: one pair register per cycle drives the memory read addresses.
   always_comb begin
      if (rp_ff < skpr_pkg::PIDX_W'(skpr_pkg::PAIRS)) begin
         fetch_cfg = pair_cfg_ff[rp_ff];
      end else begin
         fetch_cfg = '0;
      end
   end

   // Pair evaluation against the bitmap left by earlier pairs.
   always_comb begin
      pair_eval = (state_ff == skpr_pkg::ST_PAIR) && (rp_ff != '0);
      t1        = rd1_ff[cur_ff.key1[skpr_pkg::LANE_W-1:0]];
      t2        = rd2_ff[cur_ff.key2[skpr_pkg::LANE_W-1:0]];
      t_ge      = (t1 >= t2);
      t_le      = (t1 <= t2);
      pair_ok   = pair_eval && cur_ff.valid && (cur_ff.key1 != cur_ff.key2)
                  && ({1'b0, cur_ff.key1} < count_ff)
                  && ({1'b0, cur_ff.key2} < count_ff)
                  && bm_ff[cur_ff.key1] && bm_ff[cur_ff.key2];
      clr1 = 1'b0;
      clr2 = 1'b0;
      unique case (cur_ff.mode)
         skpr_pkg::MODE_NEWER: begin
            clr2 = t_ge;
            clr1 = !t_ge;
         end
         skpr_pkg::MODE_BOTH: begin
            clr1 = 1'b1;
            clr2 = 1'b1;
         end
         skpr_pkg::MODE_OLDER: begin
            clr2 = t_le;
            clr1 = !t_le;
         end
         skpr_pkg::MODE_NONE: begin
            clr1 = 1'b0;
            clr2 = 1'b0;
         end
         default: begin
            clr1 = 1'b0;
            clr2 = 1'b0;
         end
      endcase
      clear_mask = '0;
      if (pair_ok && clr1) begin
         clear_mask[cur_ff.key1] = 1'b1;
      end
      if (pair_ok && clr2) begin
         clear_mask[cur_ff.key2] = 1'b1;
      end
   end

   // Next values of the counters and the working bitmap.
   always_comb begin
      bm_in    = bm_ff;
      count_in = count_ff;
      row_in   = row_ff;
      rp_in    = rp_ff;
      if (state_ff == skpr_pkg::ST_IDLE) begin
         bm_in    = {req_keys_high, req_keys_low};
         count_in = (req_key_count > skpr_pkg::COUNT_W'(skpr_pkg::KEYS))
                    ? skpr_pkg::COUNT_W'(skpr_pkg::KEYS) : req_key_count;
         row_in   = '0;
         rp_in    = '0;
      end else if (state_ff == skpr_pkg::ST_SWEEP) begin
         row_in = row_ff + 1'b1;
      end else if (state_ff == skpr_pkg::ST_PAIR) begin
         bm_in = bm_ff & ~clear_mask;
         rp_in = rp_ff + 1'b1;
      end
   end

   // Control registers and configuration writes.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= skpr_pkg::ST_IDLE;
         enable_ff <= 1'b1;
         raw_ff    <= '0;
         row_ff    <= '0;
         rp_ff     <= '0;
         for (int p = 0; p < skpr_pkg::PAIRS; p++) begin
            if (p == 0) begin
               pair_cfg_ff[p] <= skpr_pkg::skpr_pair_type'(skpr_pkg::PAIR0_RESET);
            end else if (p == 1) begin
               pair_cfg_ff[p] <= skpr_pkg::skpr_pair_type'(skpr_pkg::PAIR1_RESET);
            end else begin
               pair_cfg_ff[p] <= '0;
            end
         end
      end else begin
         state_ff <= state_in;
         raw_ff   <= raw_in;
         row_ff   <= row_in;
         rp_ff    <= rp_in;
         if (csr_we) begin
            if (csr_index == skpr_pkg::CSR_ENABLE) begin
               enable_ff <= csr_wdata[0];
            end
            for (int p = 0; p < skpr_pkg::PAIRS; p++) begin
               if (csr_index == skpr_pkg::CSR_PAIR_BASE + skpr_pkg::CSR_IDX_W'(p)) begin
                  pair_cfg_ff[p] <= skpr_pkg::skpr_pair_type'(csr_wdata[skpr_pkg::PAIR_W-1:0]);
               end
            end
         end
      end
   end

   // Payload registers of the transaction in flight.
   always_ff @(posedge clock) begin
      bm_ff    <= bm_in;
      count_ff <= count_in;
      if (state_ff == skpr_pkg::ST_IDLE) begin
         time_ff <= req_time_ms;
      end
      if (state_ff == skpr_pkg::ST_PAIR) begin
         cur_ff <= fetch_cfg;
      end
   end

   // Press-time memory: one row written per sweep cycle, two rows read per pair.
   // A key is only compared once it has been pressed, so entries need no clearing.
   always_ff @(posedge clock) begin
      for (int l = 0; l < skpr_pkg::LANES; l++) begin
         if (wmask[l]) begin
            time_mem[row_ff][l] <= time_ff;
         end
      end
      rd1_ff <= time_mem[fetch_cfg.key1[skpr_pkg::KEY_W-1:skpr_pkg::LANE_W]];
      rd2_ff <= time_mem[fetch_cfg.key2[skpr_pkg::KEY_W-1:skpr_pkg::LANE_W]];
   end

   // Checks on the sequencer and the resolution datapath.
   `SKPR_ASSERT_IMP(a_no_accept_while_result, clock, reset, req_accept, !rsp_valid, "transaction accepted while a result is pending")
   `SKPR_ASSERT_NXT(a_bypass_one_cycle, clock, reset, req_accept && !enable_ff, rsp_valid, "disabled transaction did not complete in one cycle")
   `SKPR_ASSERT_NXT(a_sweep_to_pairs, clock, reset, (state_ff == skpr_pkg::ST_SWEEP) && (row_ff == skpr_pkg::ROW_W'(skpr_pkg::ROWS - 1)), (state_ff == skpr_pkg::ST_PAIR) && (rp_ff == '0), "sweep did not hand over to pair stage")
   `SKPR_ASSERT_NXT(a_pairs_only_clear, clock, reset, state_ff == skpr_pkg::ST_PAIR, (bm_ff & ~$past(bm_ff)) == '0, "pair resolution set a key bit")

endmodule

[tb/sv/tb_top.sv]
// Self-checking testbench for socd_key_pair_resolver_core.
// Predicts each resolved key frame with its own model of the pair resolver.
// Depends on rtl/skpr_pkg.sv and rtl/socd_key_pair_resolver_core.sv.
module tb_top;

   localparam int WATCHDOG_LIMIT   = 3000;
   localparam int HOLD_OFF_CYCLES  = 400;
   localparam int DRAIN_CYCLES     = 30;
   localparam int RANDOM_PHASES    = 8;
   localparam int FRAMES_PER_PHASE = 250;
   localparam int POOL_SIZE        = 8;
   localparam logic [skpr_pkg::CSR_IDX_W-1:0] CSR_SPARE =
      skpr_pkg::CSR_IDX_W'(skpr_pkg::CSR_PAIR_BASE + skpr_pkg::PAIRS);

   // Receiver stall patterns.
   typedef enum int {
      RX_FLOW     = 0,
      RX_LIGHT    = 1,
      RX_HEAVY    = 2,
      RX_PERIODIC = 3
   } rx_style_type;

   // Tracks key press times and pair settings, and keeps the resolved frames
   // still owed by the block in order.
   class socd_frame_scoreboard;
      bit                            enable;
      skpr_pkg::skpr_pair_type       pair_cfg[skpr_pkg::PAIRS];
      bit                            raw_down[skpr_pkg::KEYS];
      logic [skpr_pkg::TIME_W-1:0]   press_stamp[skpr_pkg::KEYS];
      logic [2*skpr_pkg::HALF_W-1:0] pending_resolved[$];
      int                            errors;

      function new();
         enable = 1'b1;
         foreach (pair_cfg[p]) pair_cfg[p] = '0;
         pair_cfg[0] = skpr_pkg::PAIR0_RESET;
         pair_cfg[1] = skpr_pkg::PAIR1_RESET;
         foreach (raw_down[k]) begin
            raw_down[k]    = 1'b0;
            press_stamp[k] = '0;
         end
         errors = 0;
      endfunction

      // Register writes outside the list are dropped by the block.
      function void note_config(logic [skpr_pkg::CSR_IDX_W-1:0] idx,
                                logic [skpr_pkg::CSR_DATA_W-1:0] data);
         if (idx == skpr_pkg::CSR_ENABLE) begin
            enable = data[0];
         end else if (idx >= skpr_pkg::CSR_PAIR_BASE &&
                      idx < skpr_pkg::CSR_PAIR_BASE + skpr_pkg::PAIRS) begin
            pair_cfg[idx - skpr_pkg::CSR_PAIR_BASE] = data[skpr_pkg::PAIR_W-1:0];
         end
      endfunction

      // Updates press tracking for one accepted frame and resolves the pairs in order.
      function void note_frame(logic [skpr_pkg::HALF_W-1:0] lo, logic [skpr_pkg::HALF_W-1:0] hi,
                               logic [skpr_pkg::COUNT_W-1:0] cnt,
                               logic [skpr_pkg::TIME_W-1:0] now_ms);
         logic [2*skpr_pkg::HALF_W-1:0] keys;
         int                            limit;
         int                            k;
         int                            p;
         skpr_pkg::skpr_pair_type       pr;
         logic [skpr_pkg::TIME_W-1:0]   t1;
         logic [skpr_pkg::TIME_W-1:0]   t2;
         keys = {hi, lo};
         if (enable) begin
            limit = (cnt > skpr_pkg::KEYS) ? skpr_pkg::KEYS : int'(cnt);
            for (k = 0; k < limit; k++) begin
               if (keys[k] && !raw_down[k]) press_stamp[k] = now_ms;
               raw_down[k] = keys[k];
            end
            // Each pair sees the bitmap left by the pairs before it.
            for (p = 0; p < skpr_pkg::PAIRS; p++) begin
               pr = pair_cfg[p];
               if (pr.valid && pr.key1 != pr.key2 && pr.key1 < limit && pr.key2 < limit &&
                   keys[pr.key1] && keys[pr.key2]) begin
                  t1 = press_stamp[pr.key1];
                  t2 = press_stamp[pr.key2];
                  case (pr.mode)
                     skpr_pkg::MODE_NEWER: begin
                        if (t1 >= t2) keys[pr.key2] = 1'b0;
                        else keys[pr.key1] = 1'b0;
                     end
                     skpr_pkg::MODE_BOTH: begin
                        keys[pr.key1] = 1'b0;
                        keys[pr.key2] = 1'b0;
                     end
                     skpr_pkg::MODE_OLDER: begin
                        if (t1 <= t2) keys[pr.key2] = 1'b0;
                        else keys[pr.key1] = 1'b0;
                     end
                     default: begin
                     end
                  endcase
               end
            end
         end
         pending_resolved.push_back(keys);
      endfunction

      // Compares one result transaction with the oldest expected frame.
      function void check_resolved(logic [skpr_pkg::HALF_W-1:0] lo,
                                   logic [skpr_pkg::HALF_W-1:0] hi);
         logic [2*skpr_pkg::HALF_W-1:0] want;
         if (pending_resolved.size() == 0) begin
            errors++;
            $display("%0t: unexpected result, actual low=%h high=%h", $time, lo, hi);
         end else begin
            want = pending_resolved.pop_front();
            if (lo !== want[skpr_pkg::HALF_W-1:0]) begin
               errors++;
               $display("%0t: resolved_low expected %h actual %h",
                        $time, want[skpr_pkg::HALF_W-1:0], lo);
            end
            if (hi !== want[2*skpr_pkg::HALF_W-1:skpr_pkg::HALF_W]) begin
               errors++;
               $display("%0t: resolved_high expected %h actual %h",
                        $time, want[2*skpr_pkg::HALF_W-1:skpr_pkg::HALF_W], hi);
            end
         end
      endfunction

      function int outstanding();
         return pending_resolved.size();
      endfunction
   endclass

   logic                            clock;
   logic                            reset;
   logic                            req_valid;
   logic                            req_stall;
   logic [skpr_pkg::HALF_W-1:0]     req_keys_low;
   logic [skpr_pkg::HALF_W-1:0]     req_keys_high;
   logic [skpr_pkg::COUNT_W-1:0]    req_key_count;
   logic [skpr_pkg::TIME_W-1:0]     req_time_ms;
   logic                            rsp_valid;
   logic                            rsp_stall;
   logic [skpr_pkg::HALF_W-1:0]     rsp_resolved_low;
   logic [skpr_pkg::HALF_W-1:0]     rsp_resolved_high;
   logic                            csr_we;
   logic [skpr_pkg::CSR_IDX_W-1:0]  csr_index;
   logic [skpr_pkg::CSR_DATA_W-1:0] csr_wdata;

   socd_frame_scoreboard frames;
   int                   burst_left  = 0;
   int                   hold_asks   = 0;
   int                   idle_cycles = 0;
   int                   key_pool[POOL_SIZE];

   socd_key_pair_resolver_core u_dut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_keys_low      (req_keys_low),
      .req_keys_high     (req_keys_high),
      .req_key_count     (req_key_count),
      .req_time_ms       (req_time_ms),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_resolved_low  (rsp_resolved_low),
      .rsp_resolved_high (rsp_resolved_high),
      .csr_we            (csr_we),
      .csr_index         (csr_index),
      .csr_wdata         (csr_wdata)
   );

   // Clock generation.
   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   function automatic logic [2*skpr_pkg::HALF_W-1:0] key_bit(int k);
      return 128'd1 << k;
   endfunction

   function automatic logic [skpr_pkg::CSR_DATA_W-1:0] pair_word(bit v,
                                                                 skpr_pkg::skpr_mode_type m,
                                                                 int k1, int k2);
      skpr_pkg::skpr_pair_type pr;
      pr.valid = v;
      pr.mode  = m;
      pr.key1  = k1[skpr_pkg::KEY_W-1:0];
      pr.key2  = k2[skpr_pkg::KEY_W-1:0];
      return pr;
   endfunction

   // Offers one frame transaction; the sender works in bursts with random gaps.
   task automatic send_frame(input logic [2*skpr_pkg::HALF_W-1:0] keys,
                             input logic [skpr_pkg::COUNT_W-1:0] cnt,
                             input logic [skpr_pkg::TIME_W-1:0] now_ms);
      int gap;
      @(negedge clock);
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 24);
         gap = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 40) : $urandom_range(0, 3);
         if (gap > 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(negedge clock);
         end
      end
      burst_left--;
      req_valid     <= 1'b1;
      req_keys_low  <= keys[skpr_pkg::HALF_W-1:0];
      req_keys_high <= keys[2*skpr_pkg::HALF_W-1:skpr_pkg::HALF_W];
      req_key_count <= cnt;
      req_time_ms   <= now_ms;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      frames.note_frame(keys[skpr_pkg::HALF_W-1:0], keys[2*skpr_pkg::HALF_W-1:skpr_pkg::HALF_W],
                        cnt, now_ms);
   endtask

   // Stops offering frames and waits until every expected result has arrived.
   task automatic drain();
      @(negedge clock);
      req_valid <= 1'b0;
      burst_left = 0;
      while (frames.outstanding() != 0) @(posedge clock);
   endtask

   task automatic write_reg(input logic [skpr_pkg::CSR_IDX_W-1:0] idx,
                            input logic [skpr_pkg::CSR_DATA_W-1:0] data);
      @(negedge clock);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      @(negedge clock);
      csr_we <= 1'b0;
      frames.note_config(idx, data);
   endtask

   // Picks a key pool for the phase and programs the registers; the pool keeps
   // the random pairs on keys that the frames actually press.
   task automatic configure_phase(input int ph);
      int p;
      for (p = 0; p < POOL_SIZE; p++) begin
         key_pool[p] = (p < POOL_SIZE / 2) ? $urandom_range(0, 63) : $urandom_range(64, 127);
      end
      if (ph % 3 == 0) key_pool[0] = 0;
      if (ph % 2 == 1) key_pool[POOL_SIZE-1] = skpr_pkg::KEYS - 1;
      drain();
      write_reg(skpr_pkg::CSR_ENABLE, (ph == 2) ? '0 : skpr_pkg::CSR_DATA_W'(1));
      for (p = 0; p < skpr_pkg::PAIRS; p++) begin
         case (ph)
            3: write_reg(skpr_pkg::CSR_IDX_W'(skpr_pkg::CSR_PAIR_BASE + p), '0);
            4: write_reg(skpr_pkg::CSR_IDX_W'(skpr_pkg::CSR_PAIR_BASE + p), '1);
            default: begin
               write_reg(skpr_pkg::CSR_IDX_W'(skpr_pkg::CSR_PAIR_BASE + p),
                         pair_word($urandom_range(0, 9) != 0,
                                   skpr_pkg::skpr_mode_type'($urandom_range(0, 3)),
                                   key_pool[$urandom_range(0, POOL_SIZE - 1)],
                                   key_pool[$urandom_range(0, POOL_SIZE - 1)]));
            end
         endcase
      end
      write_reg(CSR_SPARE, skpr_pkg::CSR_DATA_W'($urandom));
   endtask

   // Result side: checks every accepted result transaction.
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) frames.check_resolved(rsp_resolved_low,
                                                                   rsp_resolved_high);
   end

   // Counts cycles in which neither channel moves a transaction.
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
   end

   initial begin
      wait (idle_cycles >= WATCHDOG_LIMIT);
      $display("tb_top: done, errors");
      $finish;
   end

   // Receiver stall pattern, with a long hold-off whenever one is requested.
   initial begin
      rx_style_type style;
      int           span;
      int           served;
      int           hold;
      int           tick;
      rsp_stall = 1'b0;
      style     = RX_FLOW;
      span      = 0;
      served    = 0;
      tick      = 0;
      forever begin
         @(negedge clock);
         if (hold_asks != served) begin
            served = hold_asks;
            for (hold = 0; hold < HOLD_OFF_CYCLES; hold++) begin
               rsp_stall <= 1'b1;
               @(negedge clock);
            end
         end
         if (span == 0) begin
            style = rx_style_type'($urandom_range(0, 3));
            span  = $urandom_range(20, 300);
         end
         span--;
         tick++;
         case (style)
            RX_FLOW:  rsp_stall <= 1'b0;
            RX_LIGHT: rsp_stall <= ($urandom_range(0, 3) == 0);
            RX_HEAVY: rsp_stall <= ($urandom_range(0, 3) != 0);
            default:  rsp_stall <= ((tick % 5) < 2);
         endcase
      end
   end

   // Stimulus: directed frames first, then random phases.
   initial begin
      logic [2*skpr_pkg::HALF_W-1:0] held;
      logic [2*skpr_pkg::HALF_W-1:0] frame;
      logic [skpr_pkg::TIME_W-1:0]   now_ms;
      logic [skpr_pkg::COUNT_W-1:0]  cnt;
      int                            ph;
      int                            n;
      int                            roll;
      int                            p;
      frames        = new();
      reset         = 1'b1;
      req_valid     = 1'b0;
      req_keys_low  = '0;
      req_keys_high = '0;
      req_key_count = '0;
      req_time_ms   = '0;
      csr_we        = 1'b0;
      csr_index     = '0;
      csr_wdata     = '0;
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Reset pairs: 30 against 32 and 16 against 31, both keeping the newer press.
      send_frame('0, 8'd128, 32'd0);
      send_frame(key_bit(30), 8'd128, 32'd5);
      send_frame(key_bit(30) | key_bit(32), 8'd128, 32'd10);
      send_frame(key_bit(32), 8'd128, 32'd15);
      send_frame(key_bit(30) | key_bit(32), 8'd128, 32'd20);
      send_frame('0, 8'd128, 32'd25);
      // Presses in the same frame tie, and a tie keeps the first key.
      send_frame(key_bit(16) | key_bit(30) | key_bit(31) | key_bit(32), 8'd128, 32'd30);
      send_frame('1, 8'd128, 32'hFFFF_FFFF);
      // Key counts from none to above the key map; pairs past the count are skipped.
      send_frame('1, 8'd0, 32'd40);
      send_frame('1, 8'd31, 32'd41);
      send_frame('1, 8'd33, 32'd42);
      send_frame('1, 8'd129, 32'd43);
      send_frame('1, 8'd255, 32'd44);
      send_frame('1, 8'd1, 32'd45);
      send_frame('1, 8'd127, 32'd46);
      // A press after the time wraps compares as older than one before it.
      send_frame('0, 8'd128, 32'd47);
      send_frame(key_bit(16), 8'd128, 32'hFFFF_FFFF);
      send_frame(key_bit(16) | key_bit(31), 8'd128, 32'd0);

      // Every mode, a pair shadowed by an earlier one, equal keys and a high-half pair.
      drain();
      write_reg(skpr_pkg::CSR_IDX_W'(skpr_pkg::CSR_PAIR_BASE + 0),
                pair_word(1'b1, skpr_pkg::MODE_BOTH, 5, 6));
      write_reg(skpr_pkg::CSR_IDX_W'(skpr_pkg::CSR_PAIR_BASE + 1),
                pair_word(1'b1, skpr_pkg::MODE_OLDER, 6, 7));
      write_reg(skpr_pkg::CSR_IDX_W'(skpr_pkg::CSR_PAIR_BASE + 2),
                pair_word(1'b1, skpr_pkg::MODE_OLDER, 8, 9));
      write_reg(skpr_pkg::CSR_IDX_W'(skpr_pkg::CSR_PAIR_BASE + 3),
                pair_word(1'b1, skpr_pkg::MODE_NONE, 10, 11));
      write_reg(skpr_pkg::CSR_IDX_W'(skpr_pkg::CSR_PAIR_BASE + 4),
                pair_word(1'b1, skpr_pkg::MODE_NEWER, 12, 12));
      write_reg(skpr_pkg::CSR_IDX_W'(skpr_pkg::CSR_PAIR_BASE + 5),
                pair_word(1'b1, skpr_pkg::MODE_NEWER, 100, 127));
      write_reg(CSR_SPARE, '1);
      frame = key_bit(5) | key_bit(6) | key_bit(7) | key_bit(8) | key_bit(100);
      send_frame('0, 8'd128, 32'd100);
      send_frame(frame, 8'd128, 32'd101);
      frame = frame | key_bit(9) | key_bit(10) | key_bit(11) | key_bit(12) | key_bit(127);
      send_frame(frame, 8'd128, 32'd102);
      send_frame(frame, 8'd127, 32'd103);
      drain();
      write_reg(skpr_pkg::CSR_ENABLE, '0);
      send_frame('1, 8'd128, 32'd104);
      send_frame(frame, 8'd128, 32'd105);

      // Random phases: mostly evolving key states with rising time, plus noise frames.
      held   = '0;
      now_ms = $urandom;
      for (ph = 0; ph < RANDOM_PHASES; ph++) begin
         configure_phase(ph);
         if (ph == 6) now_ms = 32'hFFFF_FFF0;
         for (n = 0; n < FRAMES_PER_PHASE; n++) begin
            // Block the result side for a long stretch while frames keep coming.
            if (ph == 5 && n == 100) hold_asks++;
            roll = $urandom_range(0, 99);
            if (roll < 70) begin
               repeat ($urandom_range(1, 3)) begin
                  p = key_pool[$urandom_range(0, POOL_SIZE - 1)];
                  held[p] = ~held[p];
               end
               if ($urandom_range(0, 4) == 0) begin
                  p = $urandom_range(0, skpr_pkg::KEYS - 1);
                  held[p] = ~held[p];
               end
               frame = held;
            end else if (roll < 85) begin
               frame = {$urandom, $urandom, $urandom, $urandom};
            end else begin
               frame = held;
               for (p = 0; p < POOL_SIZE; p++) frame[key_pool[p]] = 1'b1;
            end
            if ($urandom_range(0, 49) == 0) now_ms = $urandom;
            else now_ms = now_ms + $urandom_range(0, 3);
            cnt = ($urandom_range(0, 3) == 0) ? skpr_pkg::COUNT_W'($urandom_range(0, 255))
                                              : 8'd128;
            send_frame(frame, cnt, now_ms);
         end
      end

      drain();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (frames.errors == 0) $display("tb_top: done, clean");
      else $display("tb_top: done, errors");
      $finish;
   end

endmodule

[socd_key_pair_resolver_core.f]
+incdir+rtl
rtl/skpr_pkg.sv
rtl/socd_key_pair_resolver_core.sv
tb/sv/tb_top.sv
